// ----- rtl/core/cst_pkg.sv -----
`default_nettype none

package cst_pkg;

    localparam int SLOTS    = 1024;
    localparam int ID_LIMIT = 1024;
    // slots past the 10-bit id range can never be reached
    localparam int SLOT_LIM = (SLOTS < ID_LIMIT) ? SLOTS : ID_LIMIT;

    localparam int FUNC_W = 3;
    localparam int ID_W   = 10;
    localparam int CNT_W  = 31;
    localparam int STAT_W = 3;

    localparam int TDATA_W = ((FUNC_W + ID_W + CNT_W + 7) / 8) * 8;

    // valid bits are kept as rows of one word each
    localparam int ROW_W  = 32;
    localparam int ROW_SH = 5;
    localparam int VROWS  = (SLOT_LIM + ROW_W - 1) / ROW_W;
    localparam int ROW_AW = (VROWS > 1) ? $clog2(VROWS) : 1;
    localparam int CNT_AW = (SLOT_LIM > 1) ? $clog2(SLOT_LIM) : 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FN_INIT     = 3'd0,
        FN_DESTROY  = 3'd1,
        FN_WAIT     = 3'd2,
        FN_TRYWAIT  = 3'd3,
        FN_POST     = 3'd4,
        FN_GETVALUE = 3'd5
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOSPACE    = 3'd1,
        ST_INVALID    = 3'd2,
        ST_WOULDBLOCK = 3'd3,
        ST_MUSTWAIT   = 3'd4,
        ST_OVERFLOW   = 3'd5
    } status_t;

    // reserved slot zero and the padding past the last slot read as taken
    function automatic logic [ROW_W-1:0] row_init(input logic [ROW_AW-1:0] row);
        logic [ROW_W-1:0] bits;
        int idx;
        bits = '0;
        for (int b = 0; b < ROW_W; b++) begin
            idx = int'(row) * ROW_W + b;
            bits[b] = (idx == 0) || (idx >= SLOT_LIM);
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cst_ram.sv -----
`default_nettype none

module cst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/counting_semaphore_table_top.sv -----
// channel | dir | tdata fields, lowest bit first
// s_      | in  | func[2:0], sem_id[12:3], init_value[43:13], zero pad to 48
// m_      | out | status[2:0], new_id[12:3], count_value[43:13], zero pad to 48
//
// each request first reads the valid row and the count from their rams, then a
// write-back stage modifies them, writes them back and loads the result register
// init picks its row from a per-row free flag in flops and its slot inside
// the row with a 32-bit priority encoder on the row read back
// after reset a clearing pass writes every valid row, one per cycle
// (32 rows for 1024 slots); s_tready stays low until it ends
// a full result register holds the write-back stage until m_tready
`default_nettype none

module counting_semaphore_table_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // func, sem_id, init_value
    input  wire logic [cst_pkg::TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status, new_id, count_value
    output logic      [cst_pkg::TDATA_W-1:0]   m_tdata
);

    import cst_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [ROW_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [VROWS-1:0]  free_reg, free_next;

    logic [FUNC_W-1:0] req_func_reg;
    logic [ID_W-1:0]   req_id_reg;
    logic [CNT_W-1:0]  req_val_reg;
    logic [ROW_AW-1:0] row_reg;
    logic              row_fnd_reg;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg;
    logic [ID_W-1:0]   out_new_id_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic [FUNC_W-1:0] in_func;
    logic [ID_W-1:0]   in_id;
    logic [CNT_W-1:0]  in_val;
    logic              accept;
    logic              exec_go;

    logic              vld_we, vld_re;
    logic [ROW_AW-1:0] vld_waddr, vld_raddr;
    logic [ROW_W-1:0]  vld_wdata, vld_rdata;
    logic              cnt_we, cnt_re;
    logic [CNT_AW-1:0] cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

    logic [ROW_AW-1:0] pick_row;
    logic              pick_fnd;
    logic [ROW_SH-1:0] zero_bit;
    logic              zero_fnd;
    logic [ROW_SH-1:0] id_bit;
    logic [ROW_W-1:0]  bit_mask;
    logic              id_ok;
    logic [ID_W-1:0]   alloc_id;
    logic [ROW_W-1:0]  row_set;

    logic [STAT_W-1:0] res_status;
    logic [ID_W-1:0]   res_new_id;
    logic [CNT_W-1:0]  res_count;

    assign in_func = s_tdata[FUNC_W-1:0];
    assign in_id   = s_tdata[FUNC_W+ID_W-1:FUNC_W];
    assign in_val  = s_tdata[FUNC_W+ID_W+CNT_W-1:FUNC_W+ID_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign exec_go  = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);

    // lowest row that still has a free slot
    always_comb begin
        pick_row = '0;
        pick_fnd = 1'b0;
        for (int r = VROWS - 1; r >= 0; r--) begin
            if (free_reg[r]) begin
                pick_row = ROW_AW'(r);
                pick_fnd = 1'b1;
            end
        end
    end

    // lowest clear bit of the row read back
    always_comb begin
        zero_bit = '0;
        zero_fnd = 1'b0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (!vld_rdata[b]) begin
                zero_bit = ROW_SH'(b);
                zero_fnd = 1'b1;
            end
        end
    end

    cst_ram #(.WIDTH(ROW_W), .DEPTH(VROWS)) u_vld_ram (
        .aclk  (aclk),
        .we    (vld_we),
        .waddr (vld_waddr),
        .wdata (vld_wdata),
        .re    (vld_re),
        .raddr (vld_raddr),
        .rdata (vld_rdata)
    );

    cst_ram #(.WIDTH(CNT_W), .DEPTH(SLOT_LIM)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign vld_re    = accept;
    assign vld_raddr = (func_t'(in_func) == FN_INIT) ? pick_row
                                                      : ROW_AW'(in_id >> ROW_SH);
    assign cnt_re    = accept;
    assign cnt_raddr = in_id[CNT_AW-1:0];

    assign id_bit   = req_id_reg[ROW_SH-1:0];
    assign bit_mask = ROW_W'(1) << id_bit;
    assign id_ok    = (req_id_reg != '0) && (int'(req_id_reg) < SLOT_LIM)
                      && vld_rdata[id_bit];
    assign alloc_id = ID_W'({row_reg, zero_bit});
    assign row_set  = vld_rdata | (ROW_W'(1) << zero_bit);

    always_comb begin
        res_status = ST_INVALID;
        res_new_id = '0;
        res_count  = '0;
        vld_we     = 1'b0;
        vld_waddr  = row_reg;
        vld_wdata  = vld_rdata;
        cnt_we     = 1'b0;
        cnt_waddr  = req_id_reg[CNT_AW-1:0];
        cnt_wdata  = req_val_reg;
        free_next  = free_reg;

        if (state_reg == S_CLEAR) begin
            vld_we    = 1'b1;
            vld_waddr = clr_cnt_reg;
            vld_wdata = row_init(clr_cnt_reg);
            free_next[clr_cnt_reg] = ~&row_init(clr_cnt_reg);
        end else if (state_reg == S_EXEC) begin
            case (func_t'(req_func_reg))
                FN_INIT: begin
                    if (row_fnd_reg && zero_fnd) begin
                        res_status = ST_OK;
                        res_new_id = alloc_id;
                        vld_we     = exec_go;
                        vld_wdata  = row_set;
                        cnt_we     = exec_go;
                        cnt_waddr  = alloc_id[CNT_AW-1:0];
                        cnt_wdata  = req_val_reg;
                        if (exec_go) begin
                            free_next[row_reg] = ~&row_set;
                        end
                    end else begin
                        res_status = ST_NOSPACE;
                    end
                end
                FN_DESTROY: begin
                    if (id_ok) begin
                        res_status = ST_OK;
                        vld_we     = exec_go;
                        vld_wdata  = vld_rdata & ~bit_mask;
                        if (exec_go) begin
                            free_next[row_reg] = 1'b1;
                        end
                    end
                end
                FN_WAIT, FN_TRYWAIT: begin
                    if (id_ok) begin
                        if (cnt_rdata != '0) begin
                            res_status = ST_OK;
                            cnt_we     = exec_go;
                            cnt_wdata  = cnt_rdata - CNT_W'(1);
                        end else if (func_t'(req_func_reg) == FN_WAIT) begin
                            res_status = ST_MUSTWAIT;
                        end else begin
                            res_status = ST_WOULDBLOCK;
                        end
                    end
                end
                FN_POST: begin
                    if (id_ok) begin
                        if (cnt_rdata == COUNT_MAX) begin
                            res_status = ST_OVERFLOW;
                        end else begin
                            res_status = ST_OK;
                            cnt_we     = exec_go;
                            cnt_wdata  = cnt_rdata + CNT_W'(1);
                        end
                    end
                end
                FN_GETVALUE: begin
                    if (id_ok) begin
                        res_status = ST_OK;
                        res_count  = cnt_rdata;
                    end
                end
                default: begin
                    res_status = ST_INVALID;
                end
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + ROW_AW'(1);
                if (clr_cnt_reg == ROW_AW'(VROWS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (exec_go) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_func_reg <= in_func;
            req_id_reg   <= in_id;
            req_val_reg  <= in_val;
            row_reg      <= vld_raddr;
            row_fnd_reg  <= pick_fnd;
        end
        if (exec_go) begin
            out_status_reg <= res_status;
            out_new_id_reg <= res_new_id;
            out_count_reg  <= res_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_count_reg, out_new_id_reg, out_status_reg});

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("request taken during clearing pass");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted request did not reach write-back");

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result loaded outside write-back");

    a_alloc_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_go && func_t'(req_func_reg) == FN_INIT && res_status == ST_OK)
        |-> (res_new_id != '0) && (int'(res_new_id) < SLOT_LIM))
        else $error("init handed out reserved or out-of-range slot");

    a_single_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_EXEC) |-> !cnt_we)
        else $error("count written outside write-back");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;

    import cst_pkg::*;

    localparam logic [FUNC_W-1:0] FN_RSVD_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_B = 3'd7;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 16;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        status_t          status;
        logic [ID_W-1:0]  new_id;
        logic [CNT_W-1:0] count;
    } sem_result_t;

    typedef enum {RX_OPEN, RX_LIGHT, RX_STRIDE, RX_COIN} rx_mode_t;

    class sem_scoreboard;
        bit               slot_live  [SLOTS];
        logic [CNT_W-1:0] slot_tally [SLOTS];
        int               live_total;
        int               errors;
        sem_result_t      expected_q [$];

        function new();
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            live_total = 0;
            errors     = 0;
        endfunction

        // update the semaphore table for one accepted word and queue its answer
        function void note_request(logic [TDATA_W-1:0] word);
            logic [FUNC_W-1:0] fn;
            logic [ID_W-1:0]   id;
            logic [CNT_W-1:0]  start;
            logic [CNT_W-1:0]  c;
            sem_result_t       r;
            fn       = word[FUNC_W-1:0];
            id       = word[FUNC_W +: ID_W];
            start    = word[FUNC_W+ID_W +: CNT_W];
            r.status = ST_INVALID;
            r.new_id = '0;
            r.count  = '0;
            if (fn == FN_INIT) begin
                r.status = ST_NOSPACE;
                for (int i = 1; i < SLOT_LIM; i++) begin
                    if (!slot_live[i]) begin
                        slot_live[i]  = 1'b1;
                        slot_tally[i] = start;
                        r.new_id      = ID_W'(i);
                        r.status      = ST_OK;
                        live_total++;
                        break;
                    end
                end
            end else if (fn <= FN_GETVALUE && id != 0 && int'(id) < SLOTS && slot_live[id]) begin
                c        = slot_tally[id];
                r.status = ST_OK;
                case (fn)
                    FN_DESTROY: begin
                        slot_live[id] = 1'b0;
                        live_total--;
                    end
                    FN_WAIT, FN_TRYWAIT: begin
                        if (c != '0) slot_tally[id] = c - CNT_W'(1);
                        else r.status = (fn == FN_WAIT) ? ST_MUSTWAIT : ST_WOULDBLOCK;
                    end
                    FN_POST: begin
                        if (c == COUNT_MAX) r.status = ST_OVERFLOW;
                        else slot_tally[id] = c + CNT_W'(1);
                    end
                    default: begin
                        r.count = c;
                    end
                endcase
            end
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            if (errors < PRINT_LIMIT)
                $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [TDATA_W-1:0] word);
            sem_result_t r;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no request waiting", word, 0);
                return;
            end
            r = expected_q.pop_front();
            if (word[STAT_W-1:0] !== r.status)
                report_mismatch("status", word[STAT_W-1:0], r.status);
            if (word[STAT_W +: ID_W] !== r.new_id)
                report_mismatch("new_id", word[STAT_W +: ID_W], r.new_id);
            if (word[STAT_W+ID_W +: CNT_W] !== r.count)
                report_mismatch("count_value", word[STAT_W+ID_W +: CNT_W], r.count);
            if (word[TDATA_W-1:STAT_W+ID_W+CNT_W] !== '0)
                report_mismatch("tdata padding", word[TDATA_W-1:STAT_W+ID_W+CNT_W], 0);
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        // a slot that is claimed right now, or any id when none is
        function logic [ID_W-1:0] any_live_id();
            int k;
            if (live_total <= 0) return ID_W'($urandom());
            k = $urandom_range(0, live_total - 1);
            for (int i = 1; i < SLOTS; i++) begin
                if (slot_live[i]) begin
                    if (k == 0) return ID_W'(i);
                    k--;
                end
            end
            return ID_W'($urandom());
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;

    sem_scoreboard sb = new();

    int       burst_left  = 0;
    int       idle_cycles = 0;
    rx_mode_t ready_mode  = RX_OPEN;
    int       mode_left   = 0;
    int       ready_phase = 0;

    counting_semaphore_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_request(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL counting_semaphore_table_top");
            $finish;
        end
    end

    // receiver stalls follow a randomly chosen mode, redrawn when its countdown runs out
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= rx_mode_t'($urandom_range(RX_OPEN, RX_COIN));
            mode_left  <= $urandom_range(16, 128);
        end else begin
            mode_left <= mode_left - 1;
        end
        ready_phase <= ready_phase + 1;
        case (ready_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
            RX_STRIDE: m_tready <= (ready_phase[2:0] == 3'd0);
            default:   m_tready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                             input logic [CNT_W-1:0] start);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({start, id, fn});
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        burst_left = 0;
    endtask

    // start counts near both ends so waits hit zero and posts hit the ceiling
    function automatic logic [CNT_W-1:0] pick_start_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CNT_W'(1);
            2:       return COUNT_MAX;
            3:       return COUNT_MAX - CNT_W'(1);
            4:       return CNT_W'($urandom_range(2, 5));
            default: return CNT_W'($urandom());
        endcase
    endfunction

    task automatic random_request(input int init_weight);
        logic [FUNC_W-1:0] fn;
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  start;
        start = CNT_W'($urandom());
        id    = sb.any_live_id();
        if ($urandom_range(0, 99) < init_weight) begin
            fn    = FN_INIT;
            start = pick_start_count();
            id    = ID_W'($urandom());
        end else begin
            case ($urandom_range(0, 19))
                0, 1:          fn = FN_DESTROY;
                2, 3, 4, 5:    fn = FN_WAIT;
                6, 7, 8, 9:    fn = FN_TRYWAIT;
                10, 11, 12, 13: fn = FN_POST;
                14, 15, 16, 17: fn = FN_GETVALUE;
                18:            fn = ($urandom_range(0, 1) != 0) ? FN_RSVD_A : FN_RSVD_B;
                default: begin
                    fn = FUNC_W'($urandom_range(FN_DESTROY, FN_GETVALUE));
                    id = ID_W'($urandom());
                end
            endcase
            if ($urandom_range(0, 9) == 0) id = ID_W'($urandom());
        end
        send_word(fn, id, start);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(FN_INIT, '0, '0);
        send_word(FN_INIT, ID_W'(1023), COUNT_MAX);
        send_word(FN_INIT, '0, CNT_W'(1));
        send_word(FN_WAIT, ID_W'(1), '0);
        send_word(FN_TRYWAIT, ID_W'(1), COUNT_MAX);
        send_word(FN_POST, ID_W'(2), '0);
        send_word(FN_GETVALUE, ID_W'(2), '0);
        send_word(FN_WAIT, ID_W'(2), '0);
        send_word(FN_POST, ID_W'(2), '0);
        send_word(FN_TRYWAIT, ID_W'(3), '0);
        send_word(FN_GETVALUE, ID_W'(3), '0);
        send_word(FN_POST, ID_W'(1), '0);
        send_word(FN_GETVALUE, ID_W'(1), '0);
        send_word(FN_GETVALUE, '0, '0);
        send_word(FN_DESTROY, '0, '0);
        send_word(FN_POST, ID_W'(1023), '0);
        send_word(FN_RSVD_A, ID_W'(1), COUNT_MAX);
        send_word(FN_RSVD_B, ID_W'(1023), '0);
        send_word(FN_DESTROY, ID_W'(1), '0);
        send_word(FN_GETVALUE, ID_W'(1), '0);
        send_word(FN_WAIT, ID_W'(1), '0);
        // freed slot 1 is the lowest free one again
        send_word(FN_INIT, '0, CNT_W'(32'h2AAA_AAAA));
        send_word(FN_INIT, '0, CNT_W'(32'h5555_5555));
        send_word(FN_GETVALUE, ID_W'(1), '0);
        send_word(FN_GETVALUE, ID_W'(4), '0);
        wait_results_drained();

        // grow the table across several valid rows
        repeat (350) random_request(30);
        wait_results_drained();

        // free slots across the table and let init take back the lowest ones
        repeat (150) begin
            if ($urandom_range(0, 2) == 0) random_request(40);
            else send_word(FN_DESTROY, sb.any_live_id(), CNT_W'($urandom()));
        end
        repeat (150) random_request(30);
        wait_results_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch("requests left without a result", sb.pending(), 0);
        if (sb.errors == 0) begin
            $display("PASS counting_semaphore_table_top");
        end else begin
            $display("FAIL counting_semaphore_table_top");
        end
        $finish;
    end

endmodule

`default_nettype wire
